// ===== hdl/ahr_pkg.sv =====
`timescale 1ns / 1ps

package ahr_pkg;

    // defaults for the top-level parameters
    localparam int RING_DEPTH_DEF   = 16;
    localparam int CODE_BITS_DEF    = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    // fixed field widths at the ports
    localparam int OP_W      = 2;
    localparam int CODE_W    = 64;
    localparam int CAT_W     = 2;
    localparam int PAY_W     = 32;
    localparam int LIM_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int GEN_W     = 32;

    localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_ALL = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_ACT = 2'd3;

    // classified command, front to back
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              deact;
        logic [CODE_W-1:0] code;
        logic [CAT_W-1:0]  cat;
        logic              act;
        logic [PAY_W-1:0]  pay;
        logic [LIM_W-1:0]  limit;
    } cmd_t;

endpackage

// ===== hdl/ahr_front.sv =====
`timescale 1ns / 1ps

module ahr_front
    import ahr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [OP_W-1:0]   opcode,
    input  logic [CODE_W-1:0] alarm_code,
    input  logic [CAT_W-1:0]  category,
    input  logic              is_active,
    input  logic [PAY_W-1:0]  payload,
    input  logic [LIM_W-1:0]  read_limit,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QF_W    = $clog2(Q_DEPTH + 1);

    cmd_t            q_reg [Q_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QF_W-1:0] fill_reg, fill_next;
    logic            push;
    cmd_t            in_cmd;

    always_comb
    begin
        in_cmd.op    = opcode;
        in_cmd.deact = (opcode == OP_PUSH) && !is_active;
        in_cmd.code  = alarm_code;
        in_cmd.cat   = category;
        in_cmd.act   = is_active;
        in_cmd.pay   = payload;
        if (int'(read_limit) > RING_DEPTH)
            in_cmd.limit = LIM_W'(RING_DEPTH);
        else
            in_cmd.limit = read_limit;
    end

    assign item_stall = (fill_reg == QF_W'(Q_DEPTH));
    assign push       = item_valid && !item_stall;
    assign cmd_valid  = (fill_reg != '0);
    assign cmd        = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (cmd_pop)
            rd_ptr_next = (rd_ptr_reg == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !cmd_pop)
            fill_next = fill_reg + 1'b1;
        else if (!push && cmd_pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

// ===== hdl/ahr_back.sv =====
`timescale 1ns / 1ps

module ahr_back
    import ahr_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int CODE_BITS    = CODE_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 entry_valid,
    output logic [CODE_W-1:0]    entry_code,
    output logic [CAT_W-1:0]     entry_category,
    output logic                 entry_active,
    output logic [PAY_W-1:0]     entry_payload,
    output logic                 last,
    output logic [CNT_OUT_W-1:0] stored_count,
    output logic [CNT_OUT_W-1:0] active_count,
    output logic [CAT_W-1:0]     worst_category,
    output logic [GEN_W-1:0]     generation
);

    localparam int SW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    localparam int LW = (CW > LIM_W) ? CW : LIM_W;
    localparam int NCAT = 1 << CAT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_RDOLD  = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_WALK   = 3'd5;

    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [CAT_W-1:0]     cat;
        logic [PW-1:0]        pay;
    } slot_t;

    function automatic logic [SW-1:0] prev_slot(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s == '0) ? SW'(RING_DEPTH - 1) : s - 1'b1;
        return r;
    endfunction

    slot_t ring_mem [RING_DEPTH];
    slot_t rd_data_reg;
    slot_t mem_wdata;
    logic  mem_we, mem_re;
    logic [SW-1:0] mem_raddr;

    logic [2:0]            state_reg, state_next;
    logic [SW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [GEN_W-1:0]      gen_reg, gen_next;
    logic [RING_DEPTH-1:0] flags_reg, flags_next;
    logic [CW-1:0]         cnt_reg [NCAT];
    logic [CW-1:0]         cnt_next [NCAT];
    logic [CW-1:0]         left_reg, left_next;
    logic [CW-1:0]         issued_reg, issued_next;
    logic [CW-1:0]         n_reg, n_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  res_valid_reg, res_valid_next;

    cmd_t                  cur_reg;
    logic [SW-1:0]         ptr_reg, ptr_next;
    logic [SW-1:0]         s1_slot_reg, s1_slot_next;
    logic                  s1_last_reg, s1_last_next;

    logic                  res_entry_valid_reg;
    logic [CODE_W-1:0]     res_code_reg;
    logic [CAT_W-1:0]      res_cat_reg;
    logic                  res_act_reg;
    logic [PAY_W-1:0]      res_pay_reg;
    logic                  res_last_reg;
    logic [CNT_OUT_W-1:0]  res_stored_reg;
    logic [CNT_OUT_W-1:0]  res_active_reg;
    logic [CAT_W-1:0]      res_worst_reg;
    logic [GEN_W-1:0]      res_gen_reg;

    logic [CW-1:0]  act_total;
    logic [CAT_W-1:0] worst;
    logic           out_free;
    logic           load_status, load_entry;
    logic           match, s1_move, can_go, sel, old_act;
    logic [CW-1:0]  avail;
    logic [LW-1:0]  lim_ext, avail_ext;

    assign act_total = CW'(cnt_reg[0] + cnt_reg[1] + cnt_reg[2] + cnt_reg[3]);
    assign worst = (cnt_reg[3] != '0) ? 2'd3 :
                   (cnt_reg[2] != '0) ? 2'd2 :
                   (cnt_reg[1] != '0) ? 2'd1 : 2'd0;
    assign out_free = !res_valid_reg || !result_stall;
    assign match = s1_valid_reg && flags_reg[s1_slot_reg]
                   && (rd_data_reg.code == cur_reg.code[CODE_BITS-1:0]);
    assign old_act = flags_reg[head_reg];

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        gen_next      = gen_reg;
        flags_next    = flags_reg;
        cnt_next      = cnt_reg;
        left_next     = left_reg;
        issued_next   = issued_reg;
        n_next        = n_reg;
        s1_valid_next = s1_valid_reg;
        s1_slot_next  = s1_slot_reg;
        s1_last_next  = s1_last_reg;
        ptr_next      = ptr_reg;
        res_valid_next = res_valid_reg && result_stall;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = ptr_reg;
        mem_wdata     = {cur_reg.code[CODE_BITS-1:0], cur_reg.cat, cur_reg.pay[PW-1:0]};
        cmd_pop       = 1'b0;
        load_status   = 1'b0;
        load_entry    = 1'b0;
        s1_move       = 1'b0;
        can_go        = 1'b0;
        sel           = 1'b0;
        avail         = count_reg;
        lim_ext       = '0;
        avail_ext     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            if (cmd.deact && count_reg != '0)
                            begin
                                ptr_next   = prev_slot(head_reg);
                                left_next  = count_reg;
                                state_next = ST_SEARCH;
                            end
                            else
                                state_next = ST_RDOLD;
                        end
                        OP_CLEAR:
                        begin
                            flags_next = '0;
                            for (int c = 0; c < NCAT; c++)
                                cnt_next[c] = '0;
                            head_next  = '0;
                            count_next = '0;
                            gen_next   = gen_reg + 1'b1;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            avail       = (cmd.op == OP_READ_ALL) ? count_reg : act_total;
                            lim_ext     = LW'(cmd.limit);
                            avail_ext   = LW'(avail);
                            n_next      = CW'((lim_ext < avail_ext) ? lim_ext : avail_ext);
                            issued_next = '0;
                            ptr_next    = prev_slot(head_reg);
                            state_next  = (n_next == '0) ? ST_EMIT : ST_WALK;
                        end
                    endcase
                end
            end

            // newest to oldest, one stored entry per cycle, each compared in the cycle after its read
            ST_SEARCH:
            begin
                s1_valid_next = 1'b0;
                if (match)
                begin
                    flags_next[s1_slot_reg]   = 1'b0;
                    cnt_next[rd_data_reg.cat] = cnt_reg[rd_data_reg.cat] - 1'b1;
                    state_next                = ST_RDOLD;
                end
                else if (left_reg != '0)
                begin
                    if (flags_reg[ptr_reg])
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = ptr_reg;
                        s1_valid_next = 1'b1;
                        s1_slot_next  = ptr_reg;
                    end
                    ptr_next  = prev_slot(ptr_reg);
                    left_next = left_reg - 1'b1;
                end
                else
                    state_next = ST_RDOLD;
            end

            // fetch the entry about to be overwritten, for its category
            ST_RDOLD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = head_reg;
                state_next = ST_WRITE;
            end

            ST_WRITE:
            begin
                for (int c = 0; c < NCAT; c++)
                    cnt_next[c] = cnt_reg[c]
                        - CW'(old_act && (rd_data_reg.cat == CAT_W'(c)))
                        + CW'(cur_reg.act && (cur_reg.cat == CAT_W'(c)));
                flags_next[head_reg] = cur_reg.act;
                mem_we     = 1'b1;
                head_next  = (head_reg == SW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next = (count_reg == CW'(RING_DEPTH)) ? count_reg : count_reg + 1'b1;
                gen_next   = gen_reg + 1'b1;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_status    = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_WALK:
            begin
                s1_move = s1_valid_reg && out_free;
                can_go  = !s1_valid_reg || out_free;
                if (s1_move)
                begin
                    load_entry     = 1'b1;
                    res_valid_next = 1'b1;
                end
                s1_valid_next = s1_valid_reg && !s1_move;
                if (issued_reg != n_reg)
                begin
                    sel = (cur_reg.op == OP_READ_ALL) || flags_reg[ptr_reg];
                    if (!sel)
                        ptr_next = prev_slot(ptr_reg);
                    else if (can_go)
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = ptr_reg;
                        s1_valid_next = 1'b1;
                        s1_slot_next  = ptr_reg;
                        s1_last_next  = (issued_reg == n_reg - 1'b1);
                        issued_next   = issued_reg + 1'b1;
                        ptr_next      = prev_slot(ptr_reg);
                    end
                end
                else if (!s1_valid_reg || s1_move)
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            gen_reg       <= '0;
            flags_reg     <= '0;
            for (int c = 0; c < NCAT; c++)
                cnt_reg[c] <= '0;
            left_reg      <= '0;
            issued_reg    <= '0;
            n_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            gen_reg       <= gen_next;
            flags_reg     <= flags_next;
            cnt_reg       <= cnt_next;
            left_reg      <= left_next;
            issued_reg    <= issued_next;
            n_reg         <= n_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cur_reg <= cmd;
        ptr_reg     <= ptr_next;
        s1_slot_reg <= s1_slot_next;
        s1_last_reg <= s1_last_next;
        if (load_entry)
        begin
            res_entry_valid_reg <= 1'b1;
            res_code_reg        <= CODE_W'(rd_data_reg.code);
            res_cat_reg         <= rd_data_reg.cat;
            res_act_reg         <= flags_reg[s1_slot_reg];
            res_pay_reg         <= PAY_W'(rd_data_reg.pay);
            res_last_reg        <= s1_last_reg;
        end
        else if (load_status)
        begin
            res_entry_valid_reg <= 1'b0;
            res_code_reg        <= '0;
            res_cat_reg         <= '0;
            res_act_reg         <= 1'b0;
            res_pay_reg         <= '0;
            res_last_reg        <= 1'b1;
        end
        if (load_entry || load_status)
        begin
            res_stored_reg <= CNT_OUT_W'(count_reg);
            res_active_reg <= CNT_OUT_W'(act_total);
            res_worst_reg  <= worst;
            res_gen_reg    <= gen_reg;
        end
    end

    // single-port entry store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[head_reg] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= ring_mem[mem_raddr];
    end

    assign result_valid   = res_valid_reg;
    assign entry_valid    = res_entry_valid_reg;
    assign entry_code     = res_code_reg;
    assign entry_category = res_cat_reg;
    assign entry_active   = res_act_reg;
    assign entry_payload  = res_pay_reg;
    assign last           = res_last_reg;
    assign stored_count   = res_stored_reg;
    assign active_count   = res_active_reg;
    assign worst_category = res_worst_reg;
    assign generation     = res_gen_reg;

    // per-category counters must track the flag vector
    a_flags_vs_counters: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(flags_reg) == int'(act_total))
        else $error("active counters disagree with active flags");

    a_active_le_stored: assert property (@(posedge clk) disable iff (!rst_n)
        act_total <= count_reg)
        else $error("more active entries than stored entries");

    a_s1_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (state_reg == ST_WALK || state_reg == ST_SEARCH))
        else $error("read stage busy outside a walk");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> issued_reg <= n_reg)
        else $error("walk issued more entries than requested");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_entry_valid_reg) |-> res_last_reg)
        else $error("status-only item not marked last");

endmodule

// ===== hdl/alarm_history_ring.sv =====
`timescale 1ns / 1ps

// Alarm history log: RING_DEPTH entries, oldest overwritten when full. A
// two-entry command queue decouples the input from the execution engine,
// so up to two items are taken while the engine is busy. The engine holds
// one single-port entry memory with registered read, so a search or a read
// walks stored entries one per cycle, a read only while the result side
// takes its results. A clear goes straight to its status. A push reads the
// entry it overwrites, then writes it; a deactivation first searches for the
// newest active match (the search stops at the match). A read walks the
// entries newest to oldest until the limit is met. Every item is answered
// with at least one item on the result side, the final one marked by
// last; the result register lets the engine keep going while a result
// waits.

module alarm_history_ring
    import ahr_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int CODE_BITS    = CODE_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [OP_W-1:0]      opcode,
    input  logic [CODE_W-1:0]    alarm_code,
    input  logic [CAT_W-1:0]     category,
    input  logic                 is_active,
    input  logic [PAY_W-1:0]     payload,
    input  logic [LIM_W-1:0]     read_limit,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 entry_valid,
    output logic [CODE_W-1:0]    entry_code,
    output logic [CAT_W-1:0]     entry_category,
    output logic                 entry_active,
    output logic [PAY_W-1:0]     entry_payload,
    output logic                 last,
    output logic [CNT_OUT_W-1:0] stored_count,
    output logic [CNT_OUT_W-1:0] active_count,
    output logic [CAT_W-1:0]     worst_category,
    output logic [GEN_W-1:0]     generation
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    ahr_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .alarm_code (alarm_code),
        .category   (category),
        .is_active  (is_active),
        .payload    (payload),
        .read_limit (read_limit),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    ahr_back #(
        .RING_DEPTH   (RING_DEPTH),
        .CODE_BITS    (CODE_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .entry_valid    (entry_valid),
        .entry_code     (entry_code),
        .entry_category (entry_category),
        .entry_active   (entry_active),
        .entry_payload  (entry_payload),
        .last           (last),
        .stored_count   (stored_count),
        .active_count   (active_count),
        .worst_category (worst_category),
        .generation     (generation)
    );

endmodule

// ===== sim/tb_alarm_history_ring.sv =====
`timescale 1ns / 1ps

module tb_alarm_history_ring;
    import ahr_pkg::*;

    localparam int DEPTH      = RING_DEPTH_DEF;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int MAX_CYCLES = 400000;
    localparam int HOLD_LEN   = 300;
    localparam int PHASE_LEN  = 160;
    localparam int POOL_SIZE  = 6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CODE_W-1:0] code;
        logic [CAT_W-1:0]  cat;
        logic              act;
        logic [PAY_W-1:0]  pay;
        logic [LIM_W-1:0]  limit;
    } alarm_item_t;

    typedef struct packed {
        logic                 ev;
        logic [CODE_W-1:0]    code;
        logic [CAT_W-1:0]     cat;
        logic                 act;
        logic [PAY_W-1:0]     pay;
        logic                 lst;
        logic [CNT_OUT_W-1:0] stored;
        logic [CNT_OUT_W-1:0] active;
        logic [CAT_W-1:0]     worst;
        logic [GEN_W-1:0]     gen;
    } log_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic [OP_W-1:0]      opcode = OP_PUSH;
    logic [CODE_W-1:0]    alarm_code = '0;
    logic [CAT_W-1:0]     category = '0;
    logic                 is_active = 1'b0;
    logic [PAY_W-1:0]     payload = '0;
    logic [LIM_W-1:0]     read_limit = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic                 entry_valid;
    logic [CODE_W-1:0]    entry_code;
    logic [CAT_W-1:0]     entry_category;
    logic                 entry_active;
    logic [PAY_W-1:0]     entry_payload;
    logic                 last;
    logic [CNT_OUT_W-1:0] stored_count;
    logic [CNT_OUT_W-1:0] active_count;
    logic [CAT_W-1:0]     worst_category;
    logic [GEN_W-1:0]     generation;

    alarm_item_t pending_items[$];
    log_result_t expected_results[$];

    // predictor copy of the log
    logic [CODE_W-1:0]    log_code [DEPTH];
    logic [CAT_W-1:0]     log_cat [DEPTH];
    logic [PAY_W-1:0]     log_pay [DEPTH];
    logic                 log_act [DEPTH];
    logic [SLOT_W-1:0]    log_head = '0;
    logic [CNT_OUT_W-1:0] log_count = '0;
    logic [GEN_W-1:0]     log_gen = '0;

    logic [CODE_W-1:0] code_pool [POOL_SIZE];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    alarm_history_ring dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .opcode         (opcode),
        .alarm_code     (alarm_code),
        .category       (category),
        .is_active      (is_active),
        .payload        (payload),
        .read_limit     (read_limit),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .entry_valid    (entry_valid),
        .entry_code     (entry_code),
        .entry_category (entry_category),
        .entry_active   (entry_active),
        .entry_payload  (entry_payload),
        .last           (last),
        .stored_count   (stored_count),
        .active_count   (active_count),
        .worst_category (worst_category),
        .generation     (generation)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // slot of the i-th newest entry; depth is a power of two, so it wraps
    function automatic logic [SLOT_W-1:0] slot_of(input int i);
        logic [SLOT_W-1:0] off;
        off = SLOT_W'(i);
        return log_head - 1'b1 - off;
    endfunction

    function automatic log_result_t log_status(input logic ev, input logic [SLOT_W-1:0] s,
                                               input logic lst);
        log_result_t r;
        logic [CNT_OUT_W-1:0] n_act;
        logic [CAT_W-1:0] worst;
        logic [SLOT_W-1:0] k;
        int i;
        n_act = '0;
        worst = '0;
        for (i = 0; i < log_count; i++)
        begin
            k = slot_of(i);
            if (log_act[k])
            begin
                n_act++;
                if (log_cat[k] > worst)
                    worst = log_cat[k];
            end
        end
        r.ev     = ev;
        r.code   = ev ? log_code[s] : '0;
        r.cat    = ev ? log_cat[s] : '0;
        r.act    = ev ? log_act[s] : 1'b0;
        r.pay    = ev ? log_pay[s] : '0;
        r.lst    = lst;
        r.stored = log_count;
        r.active = n_act;
        r.worst  = worst;
        r.gen    = log_gen;
        return r;
    endfunction

    function automatic void predict_item(input alarm_item_t it);
        logic [SLOT_W-1:0] picked [DEPTH];
        logic [SLOT_W-1:0] s;
        int i;
        int n;
        int lim;
        case (it.op)
            OP_PUSH:
            begin
                // deactivation clears only the newest active entry with that code
                if (!it.act)
                begin
                    for (i = 0; i < log_count; i++)
                    begin
                        s = slot_of(i);
                        if (log_act[s] && log_code[s] == it.code)
                        begin
                            log_act[s] = 1'b0;
                            break;
                        end
                    end
                end
                log_code[log_head] = it.code;
                log_cat[log_head]  = it.cat;
                log_pay[log_head]  = it.pay;
                log_act[log_head]  = it.act;
                log_head = log_head + 1'b1;
                if (log_count != DEPTH)
                    log_count++;
                log_gen++;
                expected_results.push_back(log_status(1'b0, '0, 1'b1));
            end
            OP_CLEAR:
            begin
                for (i = 0; i < DEPTH; i++)
                    log_act[i] = 1'b0;
                log_head  = '0;
                log_count = '0;
                log_gen++;
                expected_results.push_back(log_status(1'b0, '0, 1'b1));
            end
            default:
            begin
                lim = (it.limit > DEPTH) ? DEPTH : it.limit;
                n = 0;
                for (i = 0; i < log_count && n < lim; i++)
                begin
                    s = slot_of(i);
                    if (it.op == OP_READ_ALL || log_act[s])
                    begin
                        picked[n] = s;
                        n++;
                    end
                end
                if (n == 0)
                    expected_results.push_back(log_status(1'b0, '0, 1'b1));
                else
                    for (i = 0; i < n; i++)
                        expected_results.push_back(log_status(1'b1, picked[i], i == n - 1));
            end
        endcase
    endfunction

    function automatic alarm_item_t make_item(input logic [OP_W-1:0] op,
                                              input logic [CODE_W-1:0] code,
                                              input logic [CAT_W-1:0] cat, input logic act,
                                              input logic [PAY_W-1:0] pay,
                                              input logic [LIM_W-1:0] limit);
        alarm_item_t it;
        it.op    = op;
        it.code  = code;
        it.cat   = cat;
        it.act   = act;
        it.pay   = pay;
        it.limit = limit;
        return it;
    endfunction

    // mostly pushes on a small set of codes so deactivations find matches
    function automatic alarm_item_t random_item();
        alarm_item_t it;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            it.op = OP_PUSH;
        else if (roll < 60)
            it.op = OP_CLEAR;
        else if (roll < 80)
            it.op = OP_READ_ALL;
        else
            it.op = OP_READ_ACT;
        if ($urandom_range(0, 99) < 75)
            it.code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            it.code = {$urandom, $urandom};
        it.cat   = CAT_W'($urandom_range(0, 3));
        it.act   = ($urandom_range(0, 99) < 60);
        it.pay   = $urandom;
        it.limit = LIM_W'($urandom_range(0, 31));
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] got,
                                        input logic [63:0] want);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    // item sender
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        alarm_item_t nxt;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_item(make_item(opcode, alarm_code, category, is_active, payload,
                                       read_limit));
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    item_valid <= 1'b1;
                    opcode     <= nxt.op;
                    alarm_code <= nxt.code;
                    category   <= nxt.cat;
                    is_active  <= nxt.act;
                    payload    <= nxt.pay;
                    read_limit <= nxt.limit;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver stall, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_LEN;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        log_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected, code %h", $realtime,
                             entry_code);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("entry_valid", 64'(entry_valid), 64'(want.ev));
                check_field("entry_code", 64'(entry_code), 64'(want.code));
                check_field("entry_category", 64'(entry_category), 64'(want.cat));
                check_field("entry_active", 64'(entry_active), 64'(want.act));
                check_field("entry_payload", 64'(entry_payload), 64'(want.pay));
                check_field("last", 64'(last), 64'(want.lst));
                check_field("stored_count", 64'(stored_count), 64'(want.stored));
                check_field("active_count", 64'(active_count), 64'(want.active));
                check_field("worst_category", 64'(worst_category), 64'(want.worst));
                check_field("generation", 64'(generation), 64'(want.gen));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0 || item_valid)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [CODE_W-1:0] dup_code;
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            code_pool[i] = {$urandom, $urandom};
        dup_code = code_pool[0];

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 77;

        // reads of an empty log
        pending_items.push_back(make_item(OP_READ_ALL, '0, 2'd0, 1'b0, '0, 5'd16));
        pending_items.push_back(make_item(OP_READ_ACT, '0, 2'd0, 1'b0, '0, 5'd16));
        // field extremes, then two raises of one code and its deactivation
        pending_items.push_back(make_item(OP_PUSH, '1, 2'd3, 1'b1, '1, 5'd0));
        pending_items.push_back(make_item(OP_PUSH, '0, 2'd0, 1'b1, '0, 5'd31));
        pending_items.push_back(make_item(OP_PUSH, dup_code, 2'd2, 1'b1, 32'h1111_0000, 5'd0));
        pending_items.push_back(make_item(OP_PUSH, dup_code, 2'd1, 1'b1, 32'h2222_0000, 5'd0));
        pending_items.push_back(make_item(OP_PUSH, dup_code, 2'd0, 1'b0, 32'h3333_0000, 5'd0));
        // deactivation that matches nothing
        pending_items.push_back(make_item(OP_PUSH, 64'h1234, 2'd1, 1'b0, 32'h4444_0000, 5'd0));
        pending_items.push_back(make_item(OP_READ_ALL, '0, 2'd0, 1'b0, '0, 5'd0));
        pending_items.push_back(make_item(OP_READ_ALL, '0, 2'd0, 1'b0, '0, 5'd31));
        pending_items.push_back(make_item(OP_READ_ACT, '0, 2'd0, 1'b0, '0, 5'd31));
        // overfill so the oldest entries are overwritten
        for (i = 0; i < 11; i++)
            pending_items.push_back(make_item(OP_PUSH, code_pool[i % POOL_SIZE],
                                              CAT_W'(i % 4), i % 3 != 0, $urandom, 5'd0));
        pending_items.push_back(make_item(OP_READ_ALL, '0, 2'd0, 1'b0, '0, 5'd16));
        pending_items.push_back(make_item(OP_CLEAR, '0, 2'd0, 1'b0, '0, 5'd0));
        pending_items.push_back(make_item(OP_READ_ACT, '0, 2'd0, 1'b0, '0, 5'd5));

        for (i = 0; i < PHASE_LEN; i++)
            pending_items.push_back(random_item());
        wait_drained();

        send_idle_pct = 77;
        recv_idle_pct = 12;
        for (i = 0; i < PHASE_LEN; i++)
            pending_items.push_back(random_item());
        wait_drained();

        // no idling; the receiver holds off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (i = 0; i < PHASE_LEN; i++)
            pending_items.push_back(random_item());
        hold_req = hold_req + 1;
        wait_drained();

        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== alarm_history_ring.f =====
hdl/ahr_pkg.sv
hdl/ahr_front.sv
hdl/ahr_back.sv
hdl/alarm_history_ring.sv
sim/tb_alarm_history_ring.sv
